// ===== rtl/ctcp_pkg.sv =====
// Package for the circle/triangle closest-point block: widths, payload
// structs, region codes and small arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctcp_pkg;

    localparam int CW          = 16;           // coordinate width
    localparam int RATIO_BITS  = 16;           // fraction bits of a weight
    localparam int QUEUE_DEPTH = 4;
    localparam int DIFF_W      = CW + 1;       // coordinate difference
    localparam int PROD_W      = 2 * CW + 2;   // product of two differences
    localparam int WIDE_W      = 2 * CW + 5;   // dot/cross sums and their differences

    typedef enum logic [2:0] {
        REGION_VTX_A   = 3'd0,
        REGION_VTX_B   = 3'd1,
        REGION_EDGE_AB = 3'd2,
        REGION_VTX_C   = 3'd3,
        REGION_EDGE_AC = 3'd4,
        REGION_EDGE_BC = 3'd5,
        REGION_FACE    = 3'd6
    } region_t;

    typedef struct packed {
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic        [CW-2:0] circle_radius;
        logic signed [CW-1:0] vertex_a_x;
        logic signed [CW-1:0] vertex_a_y;
        logic signed [CW-1:0] vertex_b_x;
        logic signed [CW-1:0] vertex_b_y;
        logic signed [CW-1:0] vertex_c_x;
        logic signed [CW-1:0] vertex_c_y;
    } query_t;

    typedef struct packed {
        logic signed [CW-1:0] closest_x;
        logic signed [CW-1:0] closest_y;
        logic        [2:0]    region_code;
        logic                 touches;
    } result_t;

    // Classified transaction: q = base + scale(r_vec, r) + scale(s_vec, s)
    typedef struct packed {
        region_t                  region;
        logic signed [CW-1:0]     base_x;
        logic signed [CW-1:0]     base_y;
        logic signed [DIFF_W-1:0] rvec_x;
        logic signed [DIFF_W-1:0] rvec_y;
        logic signed [DIFF_W-1:0] svec_x;
        logic signed [DIFF_W-1:0] svec_y;
        logic signed [WIDE_W-1:0] r_num;
        logic signed [WIDE_W-1:0] r_den;
        logic signed [WIDE_W-1:0] s_num;
        logic signed [WIDE_W-1:0] s_den;
        logic signed [CW-1:0]     p_x;
        logic signed [CW-1:0]     p_y;
        logic        [CW-2:0]     rad;
    } job_t;

    function automatic logic signed [DIFF_W-1:0] diff(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic signed [PROD_W-1:0] mul(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        return PROD_W'(a) * PROD_W'(b);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ctcp_front.sv =====
// Front end: differences, products, dot/cross sums and Voronoi region
// classification over five registered stages. Uses ctcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctcp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             query_valid,
    output logic                  query_ready,
    input  wire ctcp_pkg::query_t query,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output ctcp_pkg::job_t        job
);

    localparam int CW = ctcp_pkg::CW;
    localparam int DW = ctcp_pkg::DIFF_W;
    localparam int WW = ctcp_pkg::WIDE_W;
    localparam int PW = ctcp_pkg::PROD_W;

    typedef struct packed {
        logic signed [CW-1:0] a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y;
        logic        [CW-2:0] rad;
        logic signed [DW-1:0] ab_x, ab_y, ac_x, ac_y, bc_x, bc_y;
    } ctx_t;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                 adv;
    ctx_t                 ctx1_reg, ctx2_reg, ctx3_reg, ctx4_reg, ctx1_next;
    logic signed [DW-1:0] ap_x_reg, ap_y_reg, bp_x_reg, bp_y_reg, cp_x_reg, cp_y_reg;
    logic signed [PW-1:0] prod_reg [18];
    logic signed [PW-1:0] prod_next [18];
    logic signed [WW-1:0] d1_reg, d2_reg, d3_reg, d4_reg, d5_reg, d6_reg;
    logic signed [WW-1:0] n_reg, yb_reg, yc_reg;
    logic signed [WW-1:0] f_d1_reg, f_d2_reg, f_d3_reg, f_d6_reg;
    logic signed [WW-1:0] e43_reg, e56_reg, ya_reg, fn_reg, fyb_reg, fyc_reg;
    logic signed [WW-1:0] den_ab_reg, den_ac_reg, nabs_reg, ybf_reg, ycf_reg;
    logic signed [WW-1:0] den_bc;
    ctcp_pkg::job_t       job_reg, job_next;

    // hold the whole front when the last stage cannot hand off
    assign adv         = !v5_reg || job_ready;
    assign query_ready = adv;
    assign job_valid   = v5_reg;
    assign job         = job_reg;

    function automatic logic opp(
        input logic signed [WW-1:0] n,
        input logic signed [WW-1:0] x
    );
        return !((n != '0) && (x != '0) && (n[WW-1] == x[WW-1]));
    endfunction

    always_comb
    begin
        ctx1_next.a_x  = query.vertex_a_x;
        ctx1_next.a_y  = query.vertex_a_y;
        ctx1_next.b_x  = query.vertex_b_x;
        ctx1_next.b_y  = query.vertex_b_y;
        ctx1_next.c_x  = query.vertex_c_x;
        ctx1_next.c_y  = query.vertex_c_y;
        ctx1_next.p_x  = query.center_x;
        ctx1_next.p_y  = query.center_y;
        ctx1_next.rad  = query.circle_radius;
        ctx1_next.ab_x = ctcp_pkg::diff(query.vertex_b_x, query.vertex_a_x);
        ctx1_next.ab_y = ctcp_pkg::diff(query.vertex_b_y, query.vertex_a_y);
        ctx1_next.ac_x = ctcp_pkg::diff(query.vertex_c_x, query.vertex_a_x);
        ctx1_next.ac_y = ctcp_pkg::diff(query.vertex_c_y, query.vertex_a_y);
        ctx1_next.bc_x = ctcp_pkg::diff(query.vertex_c_x, query.vertex_b_x);
        ctx1_next.bc_y = ctcp_pkg::diff(query.vertex_c_y, query.vertex_b_y);
    end

    always_comb
    begin
        prod_next[0]  = ctcp_pkg::mul(ctx1_reg.ab_x, ap_x_reg);
        prod_next[1]  = ctcp_pkg::mul(ctx1_reg.ab_y, ap_y_reg);
        prod_next[2]  = ctcp_pkg::mul(ctx1_reg.ac_x, ap_x_reg);
        prod_next[3]  = ctcp_pkg::mul(ctx1_reg.ac_y, ap_y_reg);
        prod_next[4]  = ctcp_pkg::mul(ctx1_reg.ab_x, bp_x_reg);
        prod_next[5]  = ctcp_pkg::mul(ctx1_reg.ab_y, bp_y_reg);
        prod_next[6]  = ctcp_pkg::mul(ctx1_reg.ac_x, bp_x_reg);
        prod_next[7]  = ctcp_pkg::mul(ctx1_reg.ac_y, bp_y_reg);
        prod_next[8]  = ctcp_pkg::mul(ctx1_reg.ab_x, cp_x_reg);
        prod_next[9]  = ctcp_pkg::mul(ctx1_reg.ab_y, cp_y_reg);
        prod_next[10] = ctcp_pkg::mul(ctx1_reg.ac_x, cp_x_reg);
        prod_next[11] = ctcp_pkg::mul(ctx1_reg.ac_y, cp_y_reg);
        prod_next[12] = ctcp_pkg::mul(ctx1_reg.ab_x, ctx1_reg.ac_y);
        prod_next[13] = ctcp_pkg::mul(ctx1_reg.ab_y, ctx1_reg.ac_x);
        prod_next[14] = ctcp_pkg::mul(ctx1_reg.ab_x, ap_y_reg);
        prod_next[15] = ctcp_pkg::mul(ctx1_reg.ab_y, ap_x_reg);
        prod_next[16] = ctcp_pkg::mul(ap_x_reg, ctx1_reg.ac_y);
        prod_next[17] = ctcp_pkg::mul(ap_y_reg, ctx1_reg.ac_x);
    end

    // region classification, tested in priority order
    always_comb
    begin
        den_bc          = e43_reg + e56_reg;
        job_next.region = ctcp_pkg::REGION_FACE;
        job_next.base_x = ctx4_reg.a_x;
        job_next.base_y = ctx4_reg.a_y;
        job_next.rvec_x = '0;
        job_next.rvec_y = '0;
        job_next.svec_x = '0;
        job_next.svec_y = '0;
        job_next.r_num  = '0;
        job_next.r_den  = '0;
        job_next.s_num  = '0;
        job_next.s_den  = '0;
        job_next.p_x    = ctx4_reg.p_x;
        job_next.p_y    = ctx4_reg.p_y;
        job_next.rad    = ctx4_reg.rad;
        if (f_d1_reg <= 0 && f_d2_reg <= 0)
        begin
            job_next.region = ctcp_pkg::REGION_VTX_A;
        end
        else if (f_d3_reg >= 0 && e43_reg <= 0)
        begin
            job_next.region = ctcp_pkg::REGION_VTX_B;
            job_next.base_x = ctx4_reg.b_x;
            job_next.base_y = ctx4_reg.b_y;
        end
        else if (opp(fn_reg, fyc_reg) && f_d1_reg >= 0 && f_d3_reg <= 0)
        begin
            job_next.region = ctcp_pkg::REGION_EDGE_AB;
            job_next.rvec_x = ctx4_reg.ab_x;
            job_next.rvec_y = ctx4_reg.ab_y;
            job_next.r_num  = f_d1_reg;
            job_next.r_den  = den_ab_reg;
        end
        else if (f_d6_reg >= 0 && e56_reg <= 0)
        begin
            job_next.region = ctcp_pkg::REGION_VTX_C;
            job_next.base_x = ctx4_reg.c_x;
            job_next.base_y = ctx4_reg.c_y;
        end
        else if (opp(fn_reg, fyb_reg) && f_d2_reg >= 0 && f_d6_reg <= 0)
        begin
            job_next.region = ctcp_pkg::REGION_EDGE_AC;
            job_next.rvec_x = ctx4_reg.ac_x;
            job_next.rvec_y = ctx4_reg.ac_y;
            job_next.r_num  = f_d2_reg;
            job_next.r_den  = den_ac_reg;
        end
        else if (opp(fn_reg, ya_reg) && e43_reg >= 0 && e56_reg >= 0)
        begin
            job_next.region = ctcp_pkg::REGION_EDGE_BC;
            job_next.base_x = ctx4_reg.b_x;
            job_next.base_y = ctx4_reg.b_y;
            job_next.rvec_x = ctx4_reg.bc_x;
            job_next.rvec_y = ctx4_reg.bc_y;
            job_next.r_num  = e43_reg;
            job_next.r_den  = den_bc;
        end
        else
        begin
            // degenerate face has a zero denominator, so both weights drop to 0
            job_next.rvec_x = ctx4_reg.ab_x;
            job_next.rvec_y = ctx4_reg.ab_y;
            job_next.svec_x = ctx4_reg.ac_x;
            job_next.svec_y = ctx4_reg.ac_y;
            job_next.r_num  = ybf_reg;
            job_next.r_den  = nabs_reg;
            job_next.s_num  = ycf_reg;
            job_next.s_den  = nabs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= query_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx1_reg   <= ctx1_next;
            ap_x_reg   <= ctcp_pkg::diff(query.center_x, query.vertex_a_x);
            ap_y_reg   <= ctcp_pkg::diff(query.center_y, query.vertex_a_y);
            bp_x_reg   <= ctcp_pkg::diff(query.center_x, query.vertex_b_x);
            bp_y_reg   <= ctcp_pkg::diff(query.center_y, query.vertex_b_y);
            cp_x_reg   <= ctcp_pkg::diff(query.center_x, query.vertex_c_x);
            cp_y_reg   <= ctcp_pkg::diff(query.center_y, query.vertex_c_y);

            ctx2_reg   <= ctx1_reg;
            for (int i = 0; i < 18; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end

            ctx3_reg   <= ctx2_reg;
            d1_reg     <= WW'(prod_reg[0])  + WW'(prod_reg[1]);
            d2_reg     <= WW'(prod_reg[2])  + WW'(prod_reg[3]);
            d3_reg     <= WW'(prod_reg[4])  + WW'(prod_reg[5]);
            d4_reg     <= WW'(prod_reg[6])  + WW'(prod_reg[7]);
            d5_reg     <= WW'(prod_reg[8])  + WW'(prod_reg[9]);
            d6_reg     <= WW'(prod_reg[10]) + WW'(prod_reg[11]);
            n_reg      <= WW'(prod_reg[12]) - WW'(prod_reg[13]);
            yc_reg     <= WW'(prod_reg[14]) - WW'(prod_reg[15]);
            yb_reg     <= WW'(prod_reg[16]) - WW'(prod_reg[17]);

            ctx4_reg   <= ctx3_reg;
            f_d1_reg   <= d1_reg;
            f_d2_reg   <= d2_reg;
            f_d3_reg   <= d3_reg;
            f_d6_reg   <= d6_reg;
            e43_reg    <= d4_reg - d3_reg;
            e56_reg    <= d5_reg - d6_reg;
            ya_reg     <= n_reg - yb_reg - yc_reg;
            fn_reg     <= n_reg;
            fyb_reg    <= yb_reg;
            fyc_reg    <= yc_reg;
            den_ab_reg <= d1_reg - d3_reg;
            den_ac_reg <= d2_reg - d6_reg;
            nabs_reg   <= n_reg[WW-1] ? -n_reg  : n_reg;
            ybf_reg    <= n_reg[WW-1] ? -yb_reg : yb_reg;
            ycf_reg    <= n_reg[WW-1] ? -yc_reg : yc_reg;

            job_reg    <= job_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ctcp_queue.sv =====
// Short queue of classified transactions between front and back end.
// Uses ctcp_pkg::job_t.
`timescale 1ns / 1ps
`default_nettype none

module ctcp_queue #(
    parameter int DEPTH = ctcp_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire ctcp_pkg::job_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output ctcp_pkg::job_t      pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    ctcp_pkg::job_t  slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0]  count_reg;
    logic            push, pop;

    assign push_ready = (count_reg != CNW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNW'(DEPTH))
        else $error("queue count above depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/ctcp_back.sv =====
// Back end: pipelined restoring dividers for the two weights, scaling,
// saturation and the touch test. Uses ctcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctcp_back #(
    parameter int RATIO_BITS = ctcp_pkg::RATIO_BITS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire ctcp_pkg::job_t job,
    output logic                result_valid,
    input  wire logic           result_ready,
    output ctcp_pkg::result_t   result
);

    localparam int CW  = ctcp_pkg::CW;
    localparam int DW  = ctcp_pkg::DIFF_W;
    localparam int WW  = ctcp_pkg::WIDE_W;
    localparam int PW  = ctcp_pkg::PROD_W;
    localparam int RB  = RATIO_BITS;
    localparam int MW  = DW + RB + 2;     // weight times difference
    localparam int SW  = CW + 3;          // unsaturated sum
    localparam int RW  = 2 * (CW - 1);    // squared radius

    localparam logic signed [SW-1:0] Q_MAX = SW'(2 ** (CW - 1) - 1);
    localparam logic signed [SW-1:0] Q_MIN = SW'(-(2 ** (CW - 1)));

    logic                 adv;
    logic                 vld_reg   [0:RB];
    ctcp_pkg::job_t       job_reg   [0:RB];
    logic [WW-1:0]        rrem_reg  [0:RB];
    logic [WW-1:0]        srem_reg  [0:RB];
    logic [RB-1:0]        rquo_reg  [0:RB];
    logic [RB-1:0]        squo_reg  [0:RB];
    logic                 rzero_reg [0:RB];
    logic                 rone_reg  [0:RB];
    logic                 szero_reg [0:RB];
    logic                 sone_reg  [0:RB];

    logic [RB:0]          r_val, s_val;
    logic                 m_vld_reg, s_vld_reg, t_vld_reg, o_vld_reg;
    logic signed [MW-1:0] m_rx_reg, m_ry_reg, m_sx_reg, m_sy_reg;
    ctcp_pkg::job_t       m_job_reg, s_job_reg;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [CW-1:0] q_x_reg, q_y_reg, t_x_reg, t_y_reg;
    logic signed [DW-1:0] dx, dy;
    logic signed [PW-1:0] sq_x_reg, sq_y_reg;
    logic [RW-1:0]        rad2_reg;
    logic [2:0]           t_region_reg;
    logic [PW-1:0]        dist2;
    ctcp_pkg::result_t    res_reg;

    // one step of restoring division
    function automatic logic [WW+RB-1:0] div_step(
        input logic [WW-1:0] rem,
        input logic [RB-1:0] quo,
        input logic [WW-1:0] den
    );
        logic [WW-1:0] sh;
        sh = {rem[WW-2:0], 1'b0};
        if (sh >= den)
            return {sh - den, quo[RB-2:0], 1'b1};
        return {sh, quo[RB-2:0], 1'b0};
    endfunction

    function automatic logic signed [SW-1:0] floor_term(input logic signed [MW-1:0] p);
        logic signed [MW-RB-1:0] t;
        t = p[MW-1:RB];
        return SW'(t);
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        if (v > Q_MAX)
            return {1'b0, {(CW-1){1'b1}}};
        if (v < Q_MIN)
            return {1'b1, {(CW-1){1'b0}}};
        return v[CW-1:0];
    endfunction

    // stall every stage together while the output holds an untaken result
    assign adv          = !o_vld_reg || result_ready;
    assign job_ready    = adv;
    assign result_valid = o_vld_reg;
    assign result       = res_reg;

    always_comb
    begin
        r_val = rone_reg[RB] ? (RB+1)'(1) << RB :
                rzero_reg[RB] ? '0 : {1'b0, rquo_reg[RB]};
        s_val = sone_reg[RB] ? (RB+1)'(1) << RB :
                szero_reg[RB] ? '0 : {1'b0, squo_reg[RB]};
        sum_x = SW'(m_job_reg.base_x) + floor_term(m_rx_reg) + floor_term(m_sx_reg);
        sum_y = SW'(m_job_reg.base_y) + floor_term(m_ry_reg) + floor_term(m_sy_reg);
        dx    = ctcp_pkg::diff(q_x_reg, s_job_reg.p_x);
        dy    = ctcp_pkg::diff(q_y_reg, s_job_reg.p_y);
        dist2 = sq_x_reg[PW-1:0] + sq_y_reg[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= RB; k++)
                vld_reg[k] <= 1'b0;
            m_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            t_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= job_valid;
            for (int k = 1; k <= RB; k++)
                vld_reg[k] <= vld_reg[k-1];
            m_vld_reg <= vld_reg[RB];
            s_vld_reg <= m_vld_reg;
            t_vld_reg <= s_vld_reg;
            o_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            job_reg[0]   <= job;
            rrem_reg[0]  <= job.r_num;
            srem_reg[0]  <= job.s_num;
            rquo_reg[0]  <= '0;
            squo_reg[0]  <= '0;
            rzero_reg[0] <= (job.r_num <= 0) || (job.r_den <= 0);
            rone_reg[0]  <= (job.r_num > 0) && (job.r_den > 0) && (job.r_num >= job.r_den);
            szero_reg[0] <= (job.s_num <= 0) || (job.s_den <= 0);
            sone_reg[0]  <= (job.s_num > 0) && (job.s_den > 0) && (job.s_num >= job.s_den);
            for (int k = 1; k <= RB; k++)
            begin
                job_reg[k]   <= job_reg[k-1];
                {rrem_reg[k], rquo_reg[k]} <=
                    div_step(rrem_reg[k-1], rquo_reg[k-1], job_reg[k-1].r_den);
                {srem_reg[k], squo_reg[k]} <=
                    div_step(srem_reg[k-1], squo_reg[k-1], job_reg[k-1].s_den);
                rzero_reg[k] <= rzero_reg[k-1];
                rone_reg[k]  <= rone_reg[k-1];
                szero_reg[k] <= szero_reg[k-1];
                sone_reg[k]  <= sone_reg[k-1];
            end

            m_job_reg <= job_reg[RB];
            m_rx_reg  <= MW'(job_reg[RB].rvec_x) * MW'($signed({1'b0, r_val}));
            m_ry_reg  <= MW'(job_reg[RB].rvec_y) * MW'($signed({1'b0, r_val}));
            m_sx_reg  <= MW'(job_reg[RB].svec_x) * MW'($signed({1'b0, s_val}));
            m_sy_reg  <= MW'(job_reg[RB].svec_y) * MW'($signed({1'b0, s_val}));

            s_job_reg <= m_job_reg;
            q_x_reg   <= sat(sum_x);
            q_y_reg   <= sat(sum_y);

            t_x_reg      <= q_x_reg;
            t_y_reg      <= q_y_reg;
            t_region_reg <= s_job_reg.region;
            sq_x_reg     <= ctcp_pkg::mul(dx, dx);
            sq_y_reg     <= ctcp_pkg::mul(dy, dy);
            rad2_reg     <= RW'(s_job_reg.rad) * RW'(s_job_reg.rad);

            res_reg.closest_x   <= t_x_reg;
            res_reg.closest_y   <= t_y_reg;
            res_reg.region_code <= t_region_reg;
            res_reg.touches     <= (dist2 <= PW'(rad2_reg));
        end
    end

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[RB] |->
            !(rzero_reg[RB] && rone_reg[RB]) && !(szero_reg[RB] && sone_reg[RB]))
        else $error("weight both zero and one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && vld_reg[RB]) |=> vld_reg[RB] && $stable(rquo_reg[RB]))
        else $error("divider advanced during stall");

endmodule

`default_nettype wire

// ===== rtl/circle_triangle_closest_point.sv =====
// Top level: closest point on a 2D triangle to a circle center, touch test.
// Instantiates ctcp_front, ctcp_queue, ctcp_back; uses ctcp_pkg.
//
//   channel   direction  handshake                    payload
//   query     in         query_valid / query_ready    ctcp_pkg::query_t
//   result    out        result_valid / result_ready  ctcp_pkg::result_t
//
// One transaction per cycle sustained while result_ready holds. A query
// passes the front stages, the queue and the back stages; the back length is set by
// the pipelined restoring dividers, one quotient bit per stage.
// Reset clears only valid bits, queue pointers and the queue count.
// A stalled result holds the back pipeline; the queue keeps the front
// running until it fills, then query_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module circle_triangle_closest_point #(
    parameter int RATIO_BITS  = ctcp_pkg::RATIO_BITS,
    parameter int QUEUE_DEPTH = ctcp_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              query_valid,
    output logic                   query_ready,
    input  wire ctcp_pkg::query_t  query,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output ctcp_pkg::result_t      result
);

    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    ctcp_pkg::job_t fq_job, qb_job;

    // classify into Voronoi region, produce numerators and denominators
    ctcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_ready (query_ready),
        .query       (query),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job         (fq_job)
    );

    // decouple front from back so each side can stall on its own
    ctcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    // divide, scale, saturate and test against the radius
    ctcp_back #(
        .RATIO_BITS (RATIO_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (qb_valid),
        .job_ready    (qb_ready),
        .job          (qb_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
